>>> rtl/core/ilha_pkg.sv
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types and constants for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

  localparam logic [31:0] SIZE_MASK   = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT   = 32'h0000_0001;
  localparam logic [31:0] MIN_BLOCK   = 32'd16;
  localparam logic [31:0] FIRST_PAY   = 32'd8;
  localparam logic [31:0] CHUNK_RESET = 32'd4096;
  localparam logic [16:0] EXT_RESET   = 17'd4096;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_INIT,
    S_IDLE,
    S_FF_CHK,
    S_FF_EVAL,
    S_GROW,
    S_FR_RD,
    S_FR_EV,
    S_M_R1,
    S_M_R2,
    S_M_R3,
    S_M_EV,
    S_CV_RD,
    S_CV_EV,
    S_WR,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/ilha_ram.sv
// ----------------------------------------------------------------------------
// ilha_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/core/implicit_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit heap allocator over a word memory with header and footer tags.
// ----------------------------------------------------------------------------
// A zero-size request or a rejected free is answered without a heap access;
// a free reads the tags of the block and of its neighbors and writes the
// merged tags; an allocate walks the blocks first fit and writes the tags
// of the block that fits, growing the break when none does. All heap
// accesses go through the single heap memory port.
// One transfer is in work at a time. After reset the heap memory is cleared
// and then 5 tag words are written, or 3 when the reset chunk does not fit.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] req_bytes,
  input  logic [15:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] payload_addr,
  output logic [1:0]  status
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IW = $clog2(HEAP_WORDS);
  localparam logic [31:0] HEAP_TOP = 32'(HEAP_BYTES);
  // The reset chunk fits when the prologue, the chunk and the epilogue do.
  localparam bit CHUNK_FITS = (16 + 4096) <= HEAP_BYTES;
  localparam logic [2:0] INIT_LAST = CHUNK_FITS ? 3'd4 : 3'd2;

  ilha_pkg::state_t state, state_next;

  logic [16:0]   extend_chunk_bytes;
  logic [IW-1:0] clr_idx;
  logic [2:0]    init_step;
  logic [16:0]   asize;
  logic [31:0]   bp;
  logic [31:0]   brk;
  logic [31:0]   cur;
  logic [31:0]   pf;
  logic          ret_free;
  logic [15:0]   res_pay;
  logic [1:0]    res_st;

  // A short list of tag writes, played out one per cycle by S_WR.
  logic [31:0]       wl_addr [4];
  logic [31:0]       wl_data [4];
  logic [1:0]        wl_idx;
  logic [1:0]        wl_last;
  ilha_pkg::state_t  wl_ret;

  // Memory port, in byte addresses; accesses outside the heap are dropped.
  logic        mem_en;
  logic        mem_we;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;
  logic        mem_inr;
  logic        inr_q;
  logic [31:0] ram_rdata;
  logic [31:0] rdv;

  assign mem_inr = mem_addr < HEAP_TOP;
  assign rdv = inr_q ? ram_rdata : 32'd0;

  ilha_ram #(
    .WIDTH(32),
    .DEPTH(HEAP_WORDS)
  ) u_heap (
    .clk  (clk),
    .en   (mem_en && mem_inr),
    .we   (mem_we),
    .addr (mem_addr[IW+1:2]),
    .wdata(mem_wdata),
    .rdata(ram_rdata)
  );

  // Decode of the request and of the tags just read.
  logic [16:0] req_round;
  logic [16:0] asize_in;
  logic [31:0] sz;
  logic [16:0] ext;
  logic [17:0] grow_size;
  logic [31:0] grow_size32;
  logic [31:0] psz;
  logic [31:0] nsz;
  logic [31:0] rem;
  logic        ff_in_heap;

  assign req_round   = {1'b0, req_bytes} + 17'd15;
  assign asize_in    = (req_bytes <= 16'd8) ? 17'd16 : {req_round[16:3], 3'b000};
  assign sz          = rdv & ilha_pkg::SIZE_MASK;
  assign ext         = (asize > extend_chunk_bytes) ? asize : extend_chunk_bytes;
  // Growth is rounded to an even number of words.
  assign grow_size   = {1'b0, ext[16:2] + {14'd0, ext[2]}, 2'b00};
  assign grow_size32 = {14'd0, grow_size};
  assign psz         = pf & ilha_pkg::SIZE_MASK;
  assign nsz         = sz;
  assign rem         = sz - {15'd0, asize};
  assign ff_in_heap  = (bp - 32'd4) < brk;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ilha_pkg::S_CLR: begin
        if (clr_idx == IW'(HEAP_WORDS - 1)) state_next = ilha_pkg::S_INIT;
      end
      ilha_pkg::S_INIT: begin
        if (init_step == INIT_LAST) state_next = ilha_pkg::S_IDLE;
      end
      ilha_pkg::S_IDLE: begin
        if (in_valid) begin
          if (mode == ilha_pkg::MODE_ALLOC) begin
            state_next = (req_bytes == 16'd0) ? ilha_pkg::S_DONE : ilha_pkg::S_FF_CHK;
          end else if (block_addr[2:0] == 3'd0 && block_addr >= 16'd16 &&
                       {16'd0, block_addr} < brk) begin
            state_next = ilha_pkg::S_FR_RD;
          end else begin
            state_next = ilha_pkg::S_DONE;
          end
        end
      end
      ilha_pkg::S_FF_CHK: state_next = ff_in_heap ? ilha_pkg::S_FF_EVAL : ilha_pkg::S_GROW;
      ilha_pkg::S_FF_EVAL: begin
        if (sz == 32'd0) begin
          state_next = ilha_pkg::S_GROW;
        end else if (rdv[0] == 1'b0 && sz >= {15'd0, asize}) begin
          state_next = ilha_pkg::S_CV_RD;
        end else begin
          state_next = ilha_pkg::S_FF_CHK;
        end
      end
      ilha_pkg::S_GROW: begin
        if (grow_size == 18'd0 || brk + grow_size32 > HEAP_TOP) begin
          state_next = ilha_pkg::S_DONE;
        end else begin
          state_next = ilha_pkg::S_WR;
        end
      end
      ilha_pkg::S_FR_RD: state_next = ilha_pkg::S_FR_EV;
      ilha_pkg::S_FR_EV: begin
        if (rdv[0] && sz >= ilha_pkg::MIN_BLOCK && bp + sz <= brk) begin
          state_next = ilha_pkg::S_WR;
        end else begin
          state_next = ilha_pkg::S_DONE;
        end
      end
      ilha_pkg::S_M_R1: state_next = ilha_pkg::S_M_R2;
      ilha_pkg::S_M_R2: state_next = ilha_pkg::S_M_R3;
      ilha_pkg::S_M_R3: state_next = ilha_pkg::S_M_EV;
      ilha_pkg::S_M_EV: begin
        if (pf[0] && rdv[0]) begin
          state_next = ret_free ? ilha_pkg::S_DONE : ilha_pkg::S_CV_RD;
        end else begin
          state_next = ilha_pkg::S_WR;
        end
      end
      ilha_pkg::S_CV_RD: state_next = ilha_pkg::S_CV_EV;
      ilha_pkg::S_CV_EV: state_next = ilha_pkg::S_WR;
      ilha_pkg::S_WR: begin
        if (wl_idx == wl_last) state_next = wl_ret;
      end
      ilha_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = ilha_pkg::S_IDLE;
      end
      default: state_next = ilha_pkg::S_CLR;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = 32'd0;
    mem_wdata = 32'd0;
    in_ready  = 1'b0;
    case (state)
      ilha_pkg::S_CLR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = {{(30 - IW){1'b0}}, clr_idx, 2'b00};
      end
      ilha_pkg::S_INIT: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        case (init_step)
          3'd0: begin
            mem_addr  = 32'd4;
            mem_wdata = 32'd8 | ilha_pkg::ALLOC_BIT;
          end
          3'd1: begin
            mem_addr  = 32'd8;
            mem_wdata = 32'd8 | ilha_pkg::ALLOC_BIT;
          end
          3'd2: begin
            mem_addr  = 32'd12;
            mem_wdata = CHUNK_FITS ? ilha_pkg::CHUNK_RESET : ilha_pkg::ALLOC_BIT;
          end
          3'd3: begin
            mem_addr  = 32'd8 + ilha_pkg::CHUNK_RESET;
            mem_wdata = ilha_pkg::CHUNK_RESET;
          end
          default: begin
            mem_addr  = 32'd12 + ilha_pkg::CHUNK_RESET;
            mem_wdata = ilha_pkg::ALLOC_BIT;
          end
        endcase
      end
      ilha_pkg::S_IDLE: in_ready = 1'b1;
      ilha_pkg::S_FF_CHK: begin
        mem_en   = ff_in_heap;
        mem_addr = bp - 32'd4;
      end
      ilha_pkg::S_FR_RD, ilha_pkg::S_M_R1, ilha_pkg::S_CV_RD: begin
        mem_en   = 1'b1;
        mem_addr = bp - 32'd4;
      end
      ilha_pkg::S_M_R2: begin
        mem_en   = 1'b1;
        mem_addr = bp - 32'd8;
      end
      ilha_pkg::S_M_R3: begin
        mem_en   = 1'b1;
        mem_addr = bp + cur - 32'd4;
      end
      ilha_pkg::S_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = wl_addr[wl_idx];
        mem_wdata = wl_data[wl_idx];
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    inr_q <= mem_inr;
  end

  // Configuration register, written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      extend_chunk_bytes <= ilha_pkg::EXT_RESET;
    end else if (cfg_we) begin
      extend_chunk_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilha_pkg::S_CLR;
      clr_idx   <= '0;
      init_step <= 3'd0;
      out_valid <= 1'b0;
      wl_idx    <= 2'd0;
      brk       <= CHUNK_FITS ? 32'd16 + ilha_pkg::CHUNK_RESET : 32'd16;
    end else begin
      state <= state_next;
      // A result leaving while the next one is loaded keeps the valid high.
      if (out_valid && out_ready && state != ilha_pkg::S_DONE) out_valid <= 1'b0;
      case (state)
        ilha_pkg::S_CLR: clr_idx <= clr_idx + IW'(1);
        ilha_pkg::S_INIT: init_step <= init_step + 3'd1;
        ilha_pkg::S_IDLE: begin
          asize    <= asize_in;
          bp       <= (mode == ilha_pkg::MODE_ALLOC) ? ilha_pkg::FIRST_PAY
                                                     : {16'd0, block_addr};
          ret_free <= mode;
          res_pay  <= 16'd0;
          res_st   <= (mode == ilha_pkg::MODE_ALLOC && req_bytes == 16'd0)
                      ? ilha_pkg::ST_ZERO : ilha_pkg::ST_OK;
        end
        ilha_pkg::S_FF_EVAL: begin
          // Step over a block that is taken or too small.
          if (sz != 32'd0 && !(rdv[0] == 1'b0 && sz >= {15'd0, asize})) begin
            bp <= bp + sz;
          end
        end
        ilha_pkg::S_GROW: begin
          if (grow_size == 18'd0 || brk + grow_size32 > HEAP_TOP) begin
            res_st <= ilha_pkg::ST_NOMEM;
          end else begin
            // New free block at the old break, then a fresh epilogue.
            bp         <= brk;
            brk        <= brk + grow_size32;
            wl_addr[0] <= brk - 32'd4;
            wl_data[0] <= grow_size32;
            wl_addr[1] <= brk + grow_size32 - 32'd8;
            wl_data[1] <= grow_size32;
            wl_addr[2] <= brk + grow_size32 - 32'd4;
            wl_data[2] <= ilha_pkg::ALLOC_BIT;
            wl_idx     <= 2'd0;
            wl_last    <= 2'd2;
            wl_ret     <= ilha_pkg::S_M_R1;
          end
        end
        ilha_pkg::S_FR_EV: begin
          wl_addr[0] <= bp - 32'd4;
          wl_data[0] <= sz;
          wl_addr[1] <= bp + sz - 32'd8;
          wl_data[1] <= sz;
          wl_idx     <= 2'd0;
          wl_last    <= 2'd1;
          wl_ret     <= ilha_pkg::S_M_R1;
        end
        ilha_pkg::S_M_R2: cur <= sz;
        ilha_pkg::S_M_R3: pf  <= rdv;
        ilha_pkg::S_M_EV: begin
          // Merge with the free neighbors; the header moves down when the
          // block below is free.
          wl_idx  <= 2'd0;
          wl_last <= 2'd1;
          wl_ret  <= ret_free ? ilha_pkg::S_DONE : ilha_pkg::S_CV_RD;
          if (pf[0]) begin
            wl_addr[0] <= bp - 32'd4;
            wl_data[0] <= cur + nsz;
            wl_addr[1] <= bp + cur + nsz - 32'd8;
            wl_data[1] <= cur + nsz;
          end else if (rdv[0]) begin
            wl_addr[0] <= bp + cur - 32'd8;
            wl_data[0] <= cur + psz;
            wl_addr[1] <= bp - psz - 32'd4;
            wl_data[1] <= cur + psz;
            bp         <= bp - psz;
          end else begin
            wl_addr[0] <= bp - psz - 32'd4;
            wl_data[0] <= cur + psz + nsz;
            wl_addr[1] <= bp + cur + nsz - 32'd8;
            wl_data[1] <= cur + psz + nsz;
            bp         <= bp - psz;
          end
        end
        ilha_pkg::S_CV_EV: begin
          // Split off the tail when at least a minimum block remains.
          wl_idx  <= 2'd0;
          wl_ret  <= ilha_pkg::S_DONE;
          res_pay <= bp[15:0];
          res_st  <= ilha_pkg::ST_OK;
          if (rem >= ilha_pkg::MIN_BLOCK) begin
            wl_addr[0] <= bp - 32'd4;
            wl_data[0] <= {15'd0, asize} | ilha_pkg::ALLOC_BIT;
            wl_addr[1] <= bp + {15'd0, asize} - 32'd8;
            wl_data[1] <= {15'd0, asize} | ilha_pkg::ALLOC_BIT;
            wl_addr[2] <= bp + {15'd0, asize} - 32'd4;
            wl_data[2] <= rem;
            wl_addr[3] <= bp + {15'd0, asize} + rem - 32'd8;
            wl_data[3] <= rem;
            wl_last    <= 2'd3;
          end else begin
            wl_addr[0] <= bp - 32'd4;
            wl_data[0] <= sz | ilha_pkg::ALLOC_BIT;
            wl_addr[1] <= bp + sz - 32'd8;
            wl_data[1] <= sz | ilha_pkg::ALLOC_BIT;
            wl_last    <= 2'd1;
          end
        end
        ilha_pkg::S_WR: wl_idx <= wl_idx + 2'd1;
        ilha_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            payload_addr <= res_pay;
            status       <= res_st;
          end
        end
        default: begin
          wl_idx <= wl_idx;
        end
      endcase
    end
  end

endmodule
